@@ rtl/vlne_pkg.sv @@
// ----------------------------------------------------------------------------
// vlne_pkg
// Shared widths, types and tables of the voxel neighbour enumerator.
// ----------------------------------------------------------------------------
`default_nettype none

package vlne_pkg;

    localparam int AXIS_BITS   = 10;
    localparam int IDX_W       = 30;
    localparam int CFG_W       = 11;
    localparam int DIM_W       = AXIS_BITS + 1;
    localparam int WL_W        = 2 * AXIS_BITS + 1;
    localparam int WLD_W       = 3 * AXIS_BITS + 1;
    localparam int CMP_W       = (WLD_W > IDX_W) ? WLD_W : IDX_W;
    localparam int DATA_W      = 32;
    localparam int PADDR_W     = 4;

    // Long division: bits retired per pipeline stage.
    localparam int STEP_PER    = 5;
    localparam int DIV1_STAGES = IDX_W / STEP_PER;
    localparam int DIV2_RAW    = ((2 * AXIS_BITS + STEP_PER - 1) / STEP_PER) * STEP_PER;
    localparam int DIV2_BITS   = (DIV2_RAW > IDX_W) ? IDX_W : DIV2_RAW;
    localparam int DIV2_STAGES = DIV2_BITS / STEP_PER;

    localparam int NUM_OFF     = 26;
    localparam int NUM_FACE    = 6;
    localparam int OFF_W       = 5;
    localparam int WGT_W       = 15;

    localparam logic [WGT_W-1:0] W_FACE   = 15'd16384;
    localparam logic [WGT_W-1:0] W_EDGE   = 15'd23170;
    localparam logic [WGT_W-1:0] W_CORNER = 15'd28378;

    typedef enum logic [1:0] {
        CLS_FACE   = 2'd0,
        CLS_EDGE   = 2'd1,
        CLS_CORNER = 2'd2
    } t_cls;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_LENGTH = 2'd1,
        REG_DEPTH  = 2'd2,
        REG_FULL   = 2'd3
    } t_reg;

    typedef struct packed {
        logic signed [1:0] dx;
        logic signed [1:0] dy;
        logic signed [1:0] dz;
        t_cls              cls;
    } t_offset;

    // Divider pipeline payload: partial remainder, dividend/quotient shifter,
    // original index and x once the first division is done.
    typedef struct packed {
        logic [DIM_W-1:0]     rem;
        logic [IDX_W-1:0]     sr;
        logic [IDX_W-1:0]     idx;
        logic [AXIS_BITS-1:0] x;
    } t_div;

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [NUM_OFF-1:0] mask;
    } t_item;

    // Clamped grid dimensions and derived products.
    typedef struct packed {
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] l;
        logic [DIM_W-1:0] d;
        logic [WL_W-1:0]  wl;
        logic [WLD_W-1:0] wld;
        logic             full;
    } t_dims;

    function automatic t_offset offset_of(input logic [OFF_W-1:0] k);
        t_offset o;
        case (k)
            5'd0:    o = '{-2'sd1,  2'sd0,  2'sd0, CLS_FACE};
            5'd1:    o = '{ 2'sd1,  2'sd0,  2'sd0, CLS_FACE};
            5'd2:    o = '{ 2'sd0, -2'sd1,  2'sd0, CLS_FACE};
            5'd3:    o = '{ 2'sd0,  2'sd1,  2'sd0, CLS_FACE};
            5'd4:    o = '{ 2'sd0,  2'sd0, -2'sd1, CLS_FACE};
            5'd5:    o = '{ 2'sd0,  2'sd0,  2'sd1, CLS_FACE};
            5'd6:    o = '{-2'sd1, -2'sd1,  2'sd0, CLS_EDGE};
            5'd7:    o = '{ 2'sd1, -2'sd1,  2'sd0, CLS_EDGE};
            5'd8:    o = '{-2'sd1,  2'sd1,  2'sd0, CLS_EDGE};
            5'd9:    o = '{ 2'sd1,  2'sd1,  2'sd0, CLS_EDGE};
            5'd10:   o = '{-2'sd1,  2'sd0, -2'sd1, CLS_EDGE};
            5'd11:   o = '{ 2'sd1,  2'sd0, -2'sd1, CLS_EDGE};
            5'd12:   o = '{-2'sd1,  2'sd0,  2'sd1, CLS_EDGE};
            5'd13:   o = '{ 2'sd1,  2'sd0,  2'sd1, CLS_EDGE};
            5'd14:   o = '{ 2'sd0, -2'sd1, -2'sd1, CLS_EDGE};
            5'd15:   o = '{ 2'sd0,  2'sd1, -2'sd1, CLS_EDGE};
            5'd16:   o = '{ 2'sd0, -2'sd1,  2'sd1, CLS_EDGE};
            5'd17:   o = '{ 2'sd0,  2'sd1,  2'sd1, CLS_EDGE};
            5'd18:   o = '{-2'sd1, -2'sd1, -2'sd1, CLS_CORNER};
            5'd19:   o = '{ 2'sd1, -2'sd1, -2'sd1, CLS_CORNER};
            5'd20:   o = '{-2'sd1,  2'sd1, -2'sd1, CLS_CORNER};
            5'd21:   o = '{ 2'sd1,  2'sd1, -2'sd1, CLS_CORNER};
            5'd22:   o = '{-2'sd1, -2'sd1,  2'sd1, CLS_CORNER};
            5'd23:   o = '{ 2'sd1, -2'sd1,  2'sd1, CLS_CORNER};
            5'd24:   o = '{-2'sd1,  2'sd1,  2'sd1, CLS_CORNER};
            5'd25:   o = '{ 2'sd1,  2'sd1,  2'sd1, CLS_CORNER};
            default: o = '{ 2'sd0,  2'sd0,  2'sd0, CLS_FACE};
        endcase
        return o;
    endfunction

    function automatic logic [WGT_W-1:0] weight_of(input t_cls c);
        logic [WGT_W-1:0] v;
        case (c)
            CLS_FACE:   v = W_FACE;
            CLS_EDGE:   v = W_EDGE;
            CLS_CORNER: v = W_CORNER;
            default:    v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/voxel_lattice_neighbour_enumerator.sv @@
// ----------------------------------------------------------------------------
// voxel_lattice_neighbour_enumerator
// Splits a linear voxel index into x, y, z and lists its in-grid neighbours.
// ----------------------------------------------------------------------------
//
//  channel   signals                                   handshake
//  -------   ---------------------------------------   --------------------------
//  command   i_vertex_index                            start high, busy low
//  result    o_neighbour_index, o_weight_class,        o_valid, one cycle, no hold
//            o_step_weight, o_empty_res, o_last
//  config    psel penable pwrite paddr pwdata prdata   APB, pready tied high
//
//  An index runs through ten long-division stages (five quotient bits each),
//  one mask stage, the walker and two output stages before its first result
//  beat. The walker emits one beat per cycle: one per neighbour, or a single
//  empty beat, up to 26 in full connectivity; a new index may enter every
//  cycle while the stages ahead of the walker have room. Reset is
//  synchronous, active low, and clears the valid bits, the walker mask and
//  the config registers. The receiver cannot stall: busy rises only when
//  the walker backs up the whole division pipeline.
//
// ----------------------------------------------------------------------------
`default_nettype none

module voxel_lattice_neighbour_enumerator
    import vlne_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Command
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [IDX_W-1:0]   i_vertex_index,
    // Result
    output logic                    o_valid,
    output logic [IDX_W-1:0]        o_neighbour_index,
    output logic [1:0]              o_weight_class,
    output logic [WGT_W-1:0]        o_step_weight,
    output logic                    o_empty_res,
    output logic                    o_last,
    // Configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic      [DATA_W-1:0]  prdata,
    output logic                    pready
);

    t_dims dims;

    // First division: index / W gives x (remainder) and y + L*z (quotient).
    t_div  d1_data  [DIV1_STAGES+1];
    logic  d1_valid [DIV1_STAGES+1];
    logic  d1_ready [DIV1_STAGES+1];

    // Second division: quotient / L gives y (remainder) and z (quotient).
    t_div  d2_data  [DIV2_STAGES+1];
    logic  d2_valid [DIV2_STAGES+1];
    logic  d2_ready [DIV2_STAGES+1];

    t_item item;
    logic  item_valid;
    logic  item_ready;

    vlne_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_dims  (dims)
    );

    // Hold off new commands while the first division stage is full and stuck.
    assign busy        = !d1_ready[0];
    assign d1_valid[0] = start;
    assign d1_data[0]  = '{rem: '0, sr: i_vertex_index, idx: i_vertex_index, x: '0};

    for (genvar g = 0; g < DIV1_STAGES; g++) begin : g_div1
        vlne_div_stage u_stage (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_divisor (dims.w),
            .i_valid   (d1_valid[g]),
            .i_data    (d1_data[g]),
            .o_ready   (d1_ready[g]),
            .o_valid   (d1_valid[g+1]),
            .o_data    (d1_data[g+1]),
            .i_ready   (d1_ready[g+1])
        );
    end

    // Restart the shifter on the low quotient bits of the first division;
    // bits above them are zero for any index inside the grid.
    assign d2_valid[0]          = d1_valid[DIV1_STAGES];
    assign d1_ready[DIV1_STAGES] = d2_ready[0];
    assign d2_data[0] = '{
        rem: '0,
        sr:  d1_data[DIV1_STAGES].sr << (IDX_W - DIV2_BITS),
        idx: d1_data[DIV1_STAGES].idx,
        x:   d1_data[DIV1_STAGES].rem[AXIS_BITS-1:0]
    };

    for (genvar g = 0; g < DIV2_STAGES; g++) begin : g_div2
        vlne_div_stage u_stage (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_divisor (dims.l),
            .i_valid   (d2_valid[g]),
            .i_data    (d2_data[g]),
            .o_ready   (d2_ready[g]),
            .o_valid   (d2_valid[g+1]),
            .o_data    (d2_data[g+1]),
            .i_ready   (d2_ready[g+1])
        );
    end

    // Range check and neighbour mask; a mask of zero becomes the empty beat.
    vlne_mask u_mask (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_dims  (dims),
        .i_valid (d2_valid[DIV2_STAGES]),
        .i_data  (d2_data[DIV2_STAGES]),
        .o_ready (d2_ready[DIV2_STAGES]),
        .o_valid (item_valid),
        .o_item  (item),
        .i_ready (item_ready)
    );

    // Walk the mask and drive the result beats.
    vlne_emit u_emit (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_dims            (dims),
        .i_valid           (item_valid),
        .i_item            (item),
        .o_ready           (item_ready),
        .o_valid           (o_valid),
        .o_neighbour_index (o_neighbour_index),
        .o_weight_class    (o_weight_class),
        .o_step_weight     (o_step_weight),
        .o_empty_res       (o_empty_res),
        .o_last            (o_last)
    );

endmodule

`default_nettype wire

@@ rtl/vlne_cfg.sv @@
// ----------------------------------------------------------------------------
// vlne_cfg
// Register file on the APB-style port; clamps dimensions, forms W*L, W*L*D.
// ----------------------------------------------------------------------------
`default_nettype none

module vlne_cfg
    import vlne_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic      [DATA_W-1:0]  prdata,
    output logic                    pready,
    output t_dims                   o_dims
);

    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_length;
    logic [CFG_W-1:0] r_depth;
    logic             r_full;
    logic [WL_W-1:0]  r_wl;
    logic [WLD_W-1:0] r_wld;
    logic [DIM_W-1:0] w_c;
    logic [DIM_W-1:0] l_c;
    logic [DIM_W-1:0] d_c;
    logic             wr_en;
    t_reg             reg_sel;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (int'(v) > (1 << AXIS_BITS)) begin
            r = DIM_W'(1 << AXIS_BITS);
        end else begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = t_reg'(paddr[PADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_W'(1);
            r_length <= CFG_W'(1);
            r_depth  <= CFG_W'(1);
            r_full   <= 1'b0;
        end else if (wr_en) begin
            case (reg_sel)
                REG_WIDTH:  r_width  <= pwdata[CFG_W-1:0];
                REG_LENGTH: r_length <= pwdata[CFG_W-1:0];
                REG_DEPTH:  r_depth  <= pwdata[CFG_W-1:0];
                REG_FULL:   r_full   <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    assign w_c = clamp_dim(r_width);
    assign l_c = clamp_dim(r_length);
    assign d_c = clamp_dim(r_depth);

    // Products are registered: W*L from the clamped sizes, W*L*D from the registered W*L.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl  <= WL_W'(1);
            r_wld <= WLD_W'(1);
        end else begin
            r_wl  <= WL_W'(w_c * l_c);
            r_wld <= WLD_W'(r_wl * d_c);
        end
    end

    always_comb begin
        case (reg_sel)
            REG_WIDTH:  prdata = DATA_W'(r_width);
            REG_LENGTH: prdata = DATA_W'(r_length);
            REG_DEPTH:  prdata = DATA_W'(r_depth);
            REG_FULL:   prdata = DATA_W'(r_full);
            default:    prdata = '0;
        endcase
    end

    assign o_dims = '{w: w_c, l: l_c, d: d_c, wl: r_wl, wld: r_wld, full: r_full};

endmodule

`default_nettype wire

@@ rtl/vlne_div_stage.sv @@
// ----------------------------------------------------------------------------
// vlne_div_stage
// One elastic pipeline stage of restoring long division, STEP_PER bits.
// ----------------------------------------------------------------------------
`default_nettype none

module vlne_div_stage
    import vlne_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [DIM_W-1:0] i_divisor,
    input  wire logic             i_valid,
    input  wire t_div             i_data,
    output logic                  o_ready,
    output logic                  o_valid,
    output t_div                  o_data,
    input  wire logic             i_ready
);

    logic r_valid;
    t_div r_data;
    t_div n_data;

    always_comb begin
        logic [DIM_W:0] trial;
        n_data = i_data;
        for (int s = 0; s < STEP_PER; s++) begin
            trial = {n_data.rem, n_data.sr[IDX_W-1]};
            if (trial >= {1'b0, i_divisor}) begin
                n_data.rem = DIM_W'(trial - {1'b0, i_divisor});
                n_data.sr  = {n_data.sr[IDX_W-2:0], 1'b1};
            end else begin
                n_data.rem = trial[DIM_W-1:0];
                n_data.sr  = {n_data.sr[IDX_W-2:0], 1'b0};
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

@@ rtl/vlne_mask.sv @@
// ----------------------------------------------------------------------------
// vlne_mask
// Range check and per-offset in-grid mask from the split coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module vlne_mask
    import vlne_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_dims i_dims,
    input  wire logic  i_valid,
    input  wire t_div  i_data,
    output logic       o_ready,
    output logic       o_valid,
    output t_item      o_item,
    input  wire logic  i_ready
);

    logic                 r_valid;
    t_item                r_item;
    logic [NUM_OFF-1:0]   n_mask;
    logic [AXIS_BITS-1:0] x;
    logic [AXIS_BITS-1:0] y;
    logic [AXIS_BITS-1:0] z;
    logic                 in_range;
    logic                 x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;

    function automatic logic axis_ok(input logic signed [1:0] dir,
                                     input logic lo, input logic hi);
        logic ok;
        if (dir < 0) begin
            ok = lo;
        end else if (dir > 0) begin
            ok = hi;
        end else begin
            ok = 1'b1;
        end
        return ok;
    endfunction

    assign x = i_data.x;
    assign y = i_data.rem[AXIS_BITS-1:0];
    assign z = i_data.sr[AXIS_BITS-1:0];

    assign in_range = CMP_W'(i_data.idx) < CMP_W'(i_dims.wld);
    assign x_lo = x != '0;
    assign y_lo = y != '0;
    assign z_lo = z != '0;
    assign x_hi = (DIM_W'(x) + DIM_W'(1)) != i_dims.w;
    assign y_hi = (DIM_W'(y) + DIM_W'(1)) != i_dims.l;
    assign z_hi = (DIM_W'(z) + DIM_W'(1)) != i_dims.d;

    always_comb begin
        t_offset o;
        for (int k = 0; k < NUM_OFF; k++) begin
            o = offset_of(OFF_W'(k));
            n_mask[k] = in_range && ((k < NUM_FACE) || i_dims.full)
                        && axis_ok(o.dx, x_lo, x_hi)
                        && axis_ok(o.dy, y_lo, y_hi)
                        && axis_ok(o.dz, z_lo, z_hi);
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= '{idx: i_data.idx, mask: n_mask};
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

@@ rtl/vlne_emit.sv @@
// ----------------------------------------------------------------------------
// vlne_emit
// Walks the neighbour mask lowest bit first, one result beat per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vlne_emit
    import vlne_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dims             i_dims,
    input  wire logic              i_valid,
    input  wire t_item             i_item,
    output logic                   o_ready,
    output logic                   o_valid,
    output logic [IDX_W-1:0]       o_neighbour_index,
    output logic [1:0]             o_weight_class,
    output logic [WGT_W-1:0]       o_step_weight,
    output logic                   o_empty_res,
    output logic                   o_last
);

    // Walker state
    logic [NUM_OFF-1:0] r_mask;
    logic               r_emp;
    logic [IDX_W-1:0]   r_idx;
    logic [NUM_OFF-1:0] rest;
    logic [OFF_W-1:0]   sel;
    logic               active;
    logic               final_beat;

    // Selection stage
    logic               r_a_valid;
    logic [OFF_W-1:0]   r_a_sel;
    logic               r_a_emp;
    logic               r_a_last;
    logic [IDX_W-1:0]   r_a_idx;

    // Output stage
    logic               r_b_valid;
    logic [IDX_W-1:0]   r_b_index;
    logic [1:0]         r_b_cls;
    logic [WGT_W-1:0]   r_b_wgt;
    logic               r_b_emp;
    logic               r_b_last;

    t_offset            off;
    logic [IDX_W-1:0]   tx, ty, tz;
    logic [IDX_W-1:0]   n_index;

    always_comb begin
        sel = '0;
        for (int k = NUM_OFF - 1; k >= 0; k--) begin
            if (r_mask[k]) begin
                sel = OFF_W'(k);
            end
        end
    end

    assign rest       = r_mask & (r_mask - NUM_OFF'(1));
    assign active     = (|r_mask) || r_emp;
    assign final_beat = r_emp || (rest == '0);
    assign o_ready    = !active || final_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
            r_emp  <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_mask <= i_item.mask;
            r_emp  <= ~|i_item.mask;
        end else if (active) begin
            r_mask <= rest;
            r_emp  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_idx <= i_item.idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_sel  <= sel;
        r_a_emp  <= r_emp;
        r_a_last <= final_beat;
        r_a_idx  <= r_idx;
    end

    // Neighbour index = index + dx + dy*W + dz*W*L, modulo the index width.
    assign off = offset_of(r_a_sel);

    always_comb begin
        if (off.dx < 0) begin
            tx = '1;
        end else if (off.dx > 0) begin
            tx = IDX_W'(1);
        end else begin
            tx = '0;
        end
        if (off.dy < 0) begin
            ty = IDX_W'(0) - IDX_W'(i_dims.w);
        end else if (off.dy > 0) begin
            ty = IDX_W'(i_dims.w);
        end else begin
            ty = '0;
        end
        if (off.dz < 0) begin
            tz = IDX_W'(0) - IDX_W'(i_dims.wl);
        end else if (off.dz > 0) begin
            tz = IDX_W'(i_dims.wl);
        end else begin
            tz = '0;
        end
    end

    assign n_index = r_a_idx + tx + ty + tz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_emp  <= r_a_emp;
        r_b_last <= r_a_last;
        if (r_a_emp) begin
            r_b_index <= '0;
            r_b_cls   <= '0;
            r_b_wgt   <= '0;
        end else begin
            r_b_index <= n_index;
            r_b_cls   <= off.cls;
            r_b_wgt   <= weight_of(off.cls);
        end
    end

    assign o_valid           = r_b_valid;
    assign o_neighbour_index = r_b_index;
    assign o_weight_class    = r_b_cls;
    assign o_step_weight     = r_b_wgt;
    assign o_empty_res       = r_b_emp;
    assign o_last            = r_b_last;

endmodule

`default_nettype wire
